// File: rtl/rbs_pkg.sv
// Shared constants, types and helpers for the ray/box slab tester.
// No dependencies; used by every rbs_* module and the top level.
package rbs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_WIDTH   = COORD_WIDTH + FRAC_BITS;
  localparam int IDX_WIDTH   = $clog2(COORD_WIDTH);
  // prep, one stage per quotient bit, resolve, two combine stages
  localparam int STAGES      = COORD_WIDTH + 4;
  localparam int CFG_AW      = 3;
  localparam int IN_TDATA_W  = 8 * COORD_WIDTH;
  localparam int OUT_BITS    = 1 + 2 * COORD_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_AW-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MAX_Z = 3'd5;

  localparam logic signed [COORD_WIDTH-1:0] QMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] QMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one quotient in flight
  typedef struct packed {
    logic [NUM_WIDTH-1:0]   rem;
    logic [COORD_WIDTH-1:0] quo;
    logic [COORD_WIDTH-1:0] den;
    logic                   neg;
    logic                   sat;
  } div_t;

  // per-ray data riding alongside the dividers
  typedef struct packed {
    coord_t     t0;
    coord_t     t1;
    logic [2:0] dzero;
    logic [2:0] in_slab;
  } side_t;

  typedef struct packed {
    coord_t t_lo;
    coord_t t_hi;
    logic   ok;
  } slab_t;

  // sign and saturate a finished magnitude quotient
  function automatic coord_t div_finish(div_t d);
    coord_t r;
    if (d.neg) begin
      if (d.sat || (d.quo > {1'b1, {(COORD_WIDTH-1){1'b0}}}))
        r = QMIN;
      else
        r = coord_t'(-d.quo);
    end else begin
      if (d.sat || d.quo[COORD_WIDTH-1])
        r = QMAX;
      else
        r = coord_t'(d.quo);
    end
    return r;
  endfunction

endpackage

// File: rtl/rbs_slab_prep.sv
// Slab setup for one axis: bound differences, magnitudes, signs, saturation check.
// Depends on rbs_pkg.
module rbs_slab_prep (
  input  logic            clk,
  input  logic            en,
  input  rbs_pkg::coord_t o,
  input  rbs_pkg::coord_t d,
  input  rbs_pkg::coord_t lo,
  input  rbs_pkg::coord_t hi,
  output rbs_pkg::div_t   enter,
  output rbs_pkg::div_t   leave,
  output logic            dzero,
  output logic            in_slab
);

  localparam int W = rbs_pkg::COORD_WIDTH;
  localparam int F = rbs_pkg::FRAC_BITS;

  logic [W-1:0] dmag;
  rbs_pkg::div_t enter_next, leave_next;

  function automatic rbs_pkg::div_t setup(rbs_pkg::coord_t b, rbs_pkg::coord_t org,
                                          logic dneg, logic [W-1:0] den);
    logic signed [W:0] diff;
    logic [W:0] mag;
    logic [2*W-F-1:0] lim;
    rbs_pkg::div_t r;
    diff = {b[W-1], b} - {org[W-1], org};
    mag  = diff[W] ? (W+1)'(-diff) : diff;
    lim  = (2*W-F)'(den) << (W - F);
    r.rem = {mag[W-1:0], {F{1'b0}}};
    r.quo = '0;
    r.den = den;
    r.neg = diff[W] ^ dneg;
    r.sat = (2*W-F)'(mag[W-1:0]) >= lim;
    return r;
  endfunction

  always_comb begin
    dmag = d[W-1] ? W'(-d) : W'(d);
    if (d[W-1]) begin
      enter_next = setup(hi, o, 1'b1, dmag);
      leave_next = setup(lo, o, 1'b1, dmag);
    end else begin
      enter_next = setup(lo, o, 1'b0, dmag);
      leave_next = setup(hi, o, 1'b0, dmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enter   <= enter_next;
      leave   <= leave_next;
      dzero   <= (d == '0);
      in_slab <= (o >= lo) && (o <= hi);
    end
  end

endmodule

// File: rtl/rbs_div_step.sv
// One restoring-division step: retires one quotient bit per register stage.
// Depends on rbs_pkg.
module rbs_div_step (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rbs_pkg::IDX_WIDTH-1:0] bit_idx,
  input  rbs_pkg::div_t                 din,
  output rbs_pkg::div_t                 dout
);

  localparam int W = rbs_pkg::COORD_WIDTH;
  localparam int N = rbs_pkg::NUM_WIDTH;

  logic [2*W-1:0] dsh;
  logic [2*W-1:0] rem_ext;
  rbs_pkg::div_t  dout_next;

  always_comb begin
    dsh       = (2*W)'(din.den) << bit_idx;
    rem_ext   = (2*W)'(din.rem);
    dout_next = din;
    if (rem_ext >= dsh) begin
      dout_next.rem          = din.rem - dsh[N-1:0];
      dout_next.quo[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= dout_next;
  end

endmodule

// File: rtl/rbs_resolve.sv
// Turns six finished quotients into signed slab intervals, zero directions included.
// Depends on rbs_pkg.
module rbs_resolve (
  input  logic          clk,
  input  logic          en,
  input  rbs_pkg::div_t enter [3],
  input  rbs_pkg::div_t leave [3],
  input  rbs_pkg::side_t side_in,
  output rbs_pkg::slab_t slab [3],
  output rbs_pkg::side_t side_out
);

  rbs_pkg::slab_t slab_next [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (side_in.dzero[a]) begin
        slab_next[a].t_lo = rbs_pkg::QMIN;
        slab_next[a].t_hi = rbs_pkg::QMAX;
        slab_next[a].ok   = side_in.in_slab[a];
      end else begin
        slab_next[a].t_lo = rbs_pkg::div_finish(enter[a]);
        slab_next[a].t_hi = rbs_pkg::div_finish(leave[a]);
        slab_next[a].ok   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) slab[a] <= slab_next[a];
      side_out <= side_in;
    end
  end

endmodule

// File: rtl/rbs_combine.sv
// Intersects x/y slabs, then z, then clips to the ray interval (two stages).
// Depends on rbs_pkg.
module rbs_combine (
  input  logic            clk,
  input  logic            en_xy,
  input  logic            en_out,
  input  rbs_pkg::slab_t  slab [3],
  input  rbs_pkg::side_t  side,
  output logic            hit,
  output rbs_pkg::coord_t t_enter,
  output rbs_pkg::coord_t t_exit
);

  // x/y stage
  logic            miss1;
  rbs_pkg::coord_t tmin1, tmax1, t0_1, t1_1;
  rbs_pkg::slab_t  z1;

  rbs_pkg::coord_t tmin2, tmax2;
  logic            miss2, hit_next;
  rbs_pkg::coord_t enter_next, exit_next;

  always_ff @(posedge clk) begin
    if (en_xy) begin
      miss1 <= !slab[0].ok || !slab[1].ok ||
               (slab[0].t_lo > slab[1].t_hi) || (slab[1].t_lo > slab[0].t_hi);
      tmin1 <= (slab[1].t_lo > slab[0].t_lo) ? slab[1].t_lo : slab[0].t_lo;
      tmax1 <= (slab[1].t_hi < slab[0].t_hi) ? slab[1].t_hi : slab[0].t_hi;
      z1    <= slab[2];
      t0_1  <= side.t0;
      t1_1  <= side.t1;
    end
  end

  always_comb begin
    miss2      = miss1 || !z1.ok || (tmin1 > z1.t_hi) || (z1.t_lo > tmax1);
    tmin2      = (z1.t_lo > tmin1) ? z1.t_lo : tmin1;
    tmax2      = (z1.t_hi < tmax1) ? z1.t_hi : tmax1;
    hit_next   = !miss2 && (tmin2 < t1_1) && (tmax2 > t0_1);
    enter_next = '0;
    exit_next  = '0;
    if (hit_next) begin
      enter_next = (tmin2 < t0_1) ? t0_1 : tmin2;
      exit_next  = (tmax2 > t1_1) ? t1_1 : tmax2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      hit     <= hit_next;
      t_enter <= enter_next;
      t_exit  <= exit_next;
    end
  end

endmodule

// File: rtl/ray_box_slab_intersect.sv
// Top level of the ray versus axis-aligned box tester (slab method, Q16.16).
// Depends on rbs_pkg, rbs_slab_prep, rbs_div_step, rbs_resolve, rbs_combine.
//
// One ray per transfer on the slave stream; one result per ray on the master
// stream, in order. A new ray is taken every cycle unless the output stalls.
// Stages: setup, one per quotient bit in each of the six parallel restoring
// dividers (32), one sign/saturate and two that intersect the slabs and clip
// them to the ray interval. Each stage holds its own valid bit and moves on
// when the next stage is free, so bubbles close up and a stalled master side
// loses and repeats nothing. The user must write the box corners over the cfg
// port only while no ray is in flight; the block does not enforce it. Index
// beyond five is ignored. A miss reports hit = 0 with zero distances.
module ray_box_slab_intersect (
  input  logic                               clk,
  input  logic                               rst,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near_limit, t_far_limit
  input  logic [rbs_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // hit, t_enter, t_exit, zero pad
  output logic [rbs_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [rbs_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [rbs_pkg::COORD_WIDTH-1:0]    cfg_wdata
);

  localparam int W = rbs_pkg::COORD_WIDTH;
  localparam int L = rbs_pkg::STAGES;

  rbs_pkg::coord_t box_lo [3];
  rbs_pkg::coord_t box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        rbs_pkg::REG_MIN_X: box_lo[0] <= cfg_wdata;
        rbs_pkg::REG_MIN_Y: box_lo[1] <= cfg_wdata;
        rbs_pkg::REG_MIN_Z: box_lo[2] <= cfg_wdata;
        rbs_pkg::REG_MAX_X: box_hi[0] <= cfg_wdata;
        rbs_pkg::REG_MAX_Y: box_hi[1] <= cfg_wdata;
        rbs_pkg::REG_MAX_Z: box_hi[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid chain: a stage loads when it is empty or its successor loads
  logic [L-1:0] vld;
  logic [L:0]   en;

  always_comb begin
    en[L] = m_tready;
    for (int k = L - 1; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < L; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[L-1];

  // input fields
  rbs_pkg::coord_t org [3];
  rbs_pkg::coord_t dir [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      org[a] = s_tdata[a*W +: W];
      dir[a] = s_tdata[(a+3)*W +: W];
    end
  end

  // stage 0: slab setup
  rbs_pkg::div_t  dv_en [W+1][3];
  rbs_pkg::div_t  dv_ex [W+1][3];
  rbs_pkg::side_t sd    [W+1];
  logic [2:0]     dzero0, inside0;
  rbs_pkg::coord_t t0_0, t1_0;

  for (genvar a = 0; a < 3; a++) begin : g_prep
    rbs_slab_prep u_prep (
      .clk     (clk),
      .en      (en[0]),
      .o       (org[a]),
      .d       (dir[a]),
      .lo      (box_lo[a]),
      .hi      (box_hi[a]),
      .enter   (dv_en[0][a]),
      .leave   (dv_ex[0][a]),
      .dzero   (dzero0[a]),
      .in_slab (inside0[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_0 <= s_tdata[6*W +: W];
      t1_0 <= s_tdata[7*W +: W];
    end
  end

  always_comb begin
    sd[0].t0      = t0_0;
    sd[0].t1      = t1_0;
    sd[0].dzero   = dzero0;
    sd[0].in_slab = inside0;
  end

  // stages 1..W: one quotient bit each, MSB first
  for (genvar j = 0; j < W; j++) begin : g_div
    for (genvar a = 0; a < 3; a++) begin : g_axis
      rbs_div_step u_en (
        .clk     (clk),
        .en      (en[j+1]),
        .bit_idx (rbs_pkg::IDX_WIDTH'(W - 1 - j)),
        .din     (dv_en[j][a]),
        .dout    (dv_en[j+1][a])
      );
      rbs_div_step u_ex (
        .clk     (clk),
        .en      (en[j+1]),
        .bit_idx (rbs_pkg::IDX_WIDTH'(W - 1 - j)),
        .din     (dv_ex[j][a]),
        .dout    (dv_ex[j+1][a])
      );
    end
    always_ff @(posedge clk) begin
      if (en[j+1]) sd[j+1] <= sd[j];
    end
  end

  // stage W+1: signed intervals
  rbs_pkg::slab_t slab [3];
  rbs_pkg::side_t side_r;

  rbs_resolve u_resolve (
    .clk      (clk),
    .en       (en[W+1]),
    .enter    (dv_en[W]),
    .leave    (dv_ex[W]),
    .side_in  (sd[W]),
    .slab     (slab),
    .side_out (side_r)
  );

  // stages W+2, W+3: intersect and clip; last one is the output register
  logic            hit;
  rbs_pkg::coord_t t_enter, t_exit;

  rbs_combine u_combine (
    .clk     (clk),
    .en_xy   (en[W+2]),
    .en_out  (en[W+3]),
    .slab    (slab),
    .side    (side_r),
    .hit     (hit),
    .t_enter (t_enter),
    .t_exit  (t_exit)
  );

  assign m_tdata = {{(rbs_pkg::OUT_TDATA_W - rbs_pkg::OUT_BITS){1'b0}}, t_exit, t_enter, hit};

endmodule

// File: rtl/rbs_checker.sv
// Port-level checks for ray_box_slab_intersect, bound to the top level.
// Depends on rbs_pkg and ray_box_slab_intersect.
module rbs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic [rbs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);

  localparam int W = rbs_pkg::COORD_WIDTH;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // pipeline is empty right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // a miss carries zero distances
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[2*W:1] == '0)
    else $error("miss with nonzero distances");

  // an empty or draining output never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready || !m_tvalid |-> s_tready)
    else $error("input blocked while output free");

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
